[sv/igfc_pkg.sv]
// Shared types and constants of the idle-gap frame collector.
package igfc_pkg;

	// Default and largest supported frame store size
	localparam int FRAME_BYTES_DEF = 32;
	localparam int LEN_MAX_W = 7;   // holds a length of up to 64
	localparam int ADDR_MAX_W = 6;  // addresses up to 63

	localparam int LIMIT_W = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2;
	localparam logic [LIMIT_W-1:0] IDLE_MAX = 16'hFFFF;

	// Input function codes
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Input request payload
	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} igfc_in_t;

	// Result payload
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
		logic       dropped;
	} igfc_out_t;

	// Closed-frame descriptor handed from front to back
	typedef struct packed {
		logic                 dropped;
		logic [LEN_MAX_W-1:0] length;
	} igfc_close_t;

	// Store write from the front
	typedef struct packed {
		logic                  en;
		logic                  bank;
		logic [ADDR_MAX_W-1:0] addr;
		logic [7:0]            data;
	} igfc_wr_t;

endpackage

[sv/igfc_front.sv]
// Front end: takes requests, tracks the open frame and idle time, closes frames.
module igfc_front import igfc_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  igfc_in_t            in_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LIMIT_W-1:0]  cfg_data,
	input  logic                q_full,
	output logic                q_push,
	output igfc_close_t         q_entry,
	output igfc_wr_t            wr
);

	localparam int LW = $clog2(FRAME_BYTES + 1);
	localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	logic [LW-1:0]      len_q;
	logic               open_q;
	logic               ovf_q;
	logic [LIMIT_W-1:0] idle_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               bank_q;

	logic               accept;
	logic               is_byte;
	logic               has_room;
	logic               store;
	logic               close;
	logic [LIMIT_W-1:0] idle_inc;

	// Handshake and classification
	assign in_ready  = !q_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !q_full;
	assign is_byte   = (in_data.func == FUNC_BYTE);
	assign has_room  = (len_q < LW'(FRAME_BYTES));
	assign store     = accept && is_byte && !ovf_q && has_room;

	// Saturating idle count and close decision
	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
	assign close    = accept && !is_byte && open_q && (idle_inc >= limit_q);

	// Store write and closed-frame descriptor
	assign wr.en       = store;
	assign wr.bank     = bank_q;
	assign wr.addr     = ADDR_MAX_W'(len_q[AW-1:0]);
	assign wr.data     = in_data.rx_byte;
	assign q_push      = close;
	assign q_entry.dropped = ovf_q;
	assign q_entry.length  = LEN_MAX_W'(len_q);

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			open_q  <= 1'b0;
			ovf_q   <= 1'b0;
			idle_q  <= '0;
			limit_q <= LIMIT_RESET;
			bank_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (accept && is_byte) begin
				open_q <= 1'b1;
				idle_q <= '0;
				if (store) begin
					len_q <= len_q + LW'(1);
				end else if (!ovf_q) begin
					ovf_q <= 1'b1;
				end
			end else if (close) begin
				len_q  <= '0;
				open_q <= 1'b0;
				ovf_q  <= 1'b0;
				idle_q <= '0;
				bank_q <= ~bank_q;
			end else if (accept && open_q) begin
				idle_q <= idle_inc;
			end
		end
	end

endmodule

[sv/igfc_queue.sv]
// Two-entry queue of closed-frame descriptors between front and back.
module igfc_queue import igfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  igfc_close_t push_entry,
	input  logic        pop,
	output igfc_close_t head,
	output logic        full,
	output logic        empty
);

	igfc_close_t ent_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/igfc_back.sv]
// Back end: two-bank store, flushes closed frames, one result per unstalled cycle.
module igfc_back import igfc_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  igfc_wr_t    wr,
	input  logic        q_empty,
	input  igfc_close_t q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output igfc_out_t   out_data
);

	localparam int LW = $clog2(FRAME_BYTES + 1);
	localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int MEM_DEPTH = 2 * (1 << AW);

	logic [7:0]    mem_q [MEM_DEPTH];
	logic [7:0]    rdata_q;
	logic          last_q;
	logic          drop_q;
	logic          out_valid_q;
	logic [LW-1:0] idx_q;
	logic          bank_q;

	logic          advance;
	logic          issue;
	logic          is_last;
	logic [LW-1:0] head_len;

	// Issue one result whenever a frame is queued and the output register frees up
	assign advance  = !out_valid_q || out_ready;
	assign issue    = !q_empty && advance;
	assign head_len = q_head.length[LW-1:0];
	assign is_last  = q_head.dropped || ((idx_q + LW'(1)) == head_len);
	assign q_pop    = issue && is_last;

	// Frame store: front writes one bank while the other drains
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[{wr.bank, wr.addr[AW-1:0]}] <= wr.data;
		end
		if (issue && !q_head.dropped) begin
			rdata_q <= mem_q[{bank_q, idx_q[AW-1:0]}];
		end
		if (issue) begin
			last_q <= is_last;
			drop_q <= q_head.dropped;
		end
	end

	// Flush position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			bank_q      <= 1'b0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					idx_q  <= '0;
					bank_q <= ~bank_q;
				end else begin
					idx_q <= idx_q + LW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign out_data.frame_byte = drop_q ? 8'd0 : rdata_q;
	assign out_data.last       = last_q;
	assign out_data.dropped    = drop_q;

endmodule

[sv/idle_gap_frame_collector.sv]
// Top level of the idle-gap frame collector: front, descriptor queue and back.
//
//  channel | signals                       | payload
//  --------+-------------------------------+------------------------------------
//  in      | in_valid / in_ready           | in_data: func, rx_byte
//  out     | out_valid / out_ready         | out_data: frame_byte, last, dropped
//  cfg     | cfg_valid / cfg_ready         | cfg_data: idle_limit (16 bits)
//
// A byte or tick request is taken when in_ready is high; cfg_ready is always high.
// A closed frame drains from the store memory port at one result per cycle unless
// out_ready stalls; its first result comes via the queue and the output register.
// Requests stall only while two closed frames (both store banks) await draining.
// Reset clears frame state and sets idle_limit to 2; the store needs no clearing.
module idle_gap_frame_collector import igfc_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  igfc_in_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output igfc_out_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	igfc_close_t push_entry;
	igfc_close_t head;
	igfc_wr_t    wr;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;

	igfc_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.q_full   (full),
		.q_push   (push),
		.q_entry  (push_entry),
		.wr       (wr)
	);

	igfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	igfc_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.q_empty  (empty),
		.q_head   (head),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

[sv/igfc_checker.sv]
// Port-level checks of the idle-gap frame collector, bound to the top level.
module igfc_checker import igfc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input igfc_out_t out_data
);

	// A stalled result stays offered and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or withdrawn");

	// A drop result is a single final result with a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.dropped |-> out_data.last && (out_data.frame_byte == 8'd0))
		else $error("malformed drop result");

	// Input stalls only while closed frames drain
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && $past(!in_ready) |-> out_valid)
		else $error("input stalled with no flush in progress");

endmodule

bind idle_gap_frame_collector igfc_checker u_igfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
